/* hdl/assert_macros.svh */
// Assertion helpers, clocked on clk and gated by rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/csdm_pkg.sv */
package csdm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int ROOT_STEPS = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd6;

  localparam logic signed [17:0] DIR_Z_RESET  = 18'sd65536;
  localparam logic [30:0]        RADIUS_RESET = 31'd65536;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD,
    OP_D0, OP_D1, OP_D2, OP_D3, OP_PROJ,
    OP_A0, OP_A1, OP_A2, OP_A3, OP_MAG,
    OP_S0, OP_S1, OP_S2, OP_S3,
    OP_RINIT, OP_RSTEP, OP_DEV, OP_UPD, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

/* hdl/csdm_ctrl.sv */
module csdm_ctrl
  import csdm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_ROOT, S_DEV, S_UPD, S_EMIT} state_t;

  localparam logic [4:0] RUN_LAST  = 5'd14;
  localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);

  state_t     state_r;
  logic [4:0] cnt_r;
  logic       out_valid_r;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_RUN: begin
        case (cnt_r)
          5'd0:    cmd.op = OP_D0;
          5'd1:    cmd.op = OP_D1;
          5'd2:    cmd.op = OP_D2;
          5'd3:    cmd.op = OP_D3;
          5'd4:    cmd.op = OP_PROJ;
          5'd5:    cmd.op = OP_A0;
          5'd6:    cmd.op = OP_A1;
          5'd7:    cmd.op = OP_A2;
          5'd8:    cmd.op = OP_A3;
          5'd9:    cmd.op = OP_MAG;
          5'd10:   cmd.op = OP_S0;
          5'd11:   cmd.op = OP_S1;
          5'd12:   cmd.op = OP_S2;
          5'd13:   cmd.op = OP_S3;
          5'd14:   cmd.op = OP_RINIT;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_ROOT: cmd.op = OP_RSTEP;
      S_DEV:  cmd.op = OP_DEV;
      S_UPD:  cmd.op = OP_UPD;
      S_EMIT: begin
        if (out_free) cmd.op = OP_EMIT;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_RUN;
            cnt_r   <= '0;
          end
        end
        S_RUN: begin
          if (cnt_r == RUN_LAST) begin
            state_r <= S_ROOT;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_ROOT: begin
          if (cnt_r == ROOT_LAST) state_r <= S_DEV;
          else cnt_r <= cnt_r + 5'd1;
        end
        S_DEV: state_r <= S_UPD;
        S_UPD: state_r <= status.last ? S_EMIT : S_IDLE;
        S_EMIT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/csdm_dp.sv */
module csdm_dp
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  input  logic                 in_last_point,
  output logic signed [31:0]   out_peak_deviation,
  output logic signed [31:0]   out_peak_x,
  output logic signed [31:0]   out_peak_y,
  output logic signed [31:0]   out_peak_z
);

  localparam int DOT_W  = 53;
  localparam int PROJ_W = DOT_W + 1 - FRAC_BITS;
  localparam int MA_W   = (PROJ_W > 33) ? PROJ_W : 33;
  localparam int MB_W   = 33;
  localparam int P_W    = MA_W + MB_W;
  localparam int AX_W   = PROJ_W + 19 - FRAC_BITS;
  localparam int R_W    = ((AX_W > 33) ? AX_W : 33) + 1;

  localparam logic signed [DOT_W:0] DOT_HALF = (DOT_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [P_W:0]   P_HALF   = (P_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [63:0]           SQ_MAX   = '1;
  localparam logic signed [33:0]    DEV_MAX  = 34'sh7FFFFFFF;

  // configuration
  logic signed [31:0] origin_r [3];
  logic signed [17:0] dir_r    [3];
  logic [30:0]        radius_r;

  // per point
  logic signed [31:0]     p_r   [3];
  logic signed [32:0]     v_r   [3];
  logic signed [R_W-1:0]  r_r   [3];
  logic [31:0]            mag_r [3];
  logic                   ovf_r [3];
  logic                   last_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [PROJ_W-1:0] proj_r;
  logic signed [P_W-1:0]    prod_r;
  logic [63:0]              sq_r;
  logic [63:0]              rn_r, root_r, bit_r;
  logic signed [31:0]       dev_r;

  // running peak
  logic signed [31:0] best_dev_r;
  logic signed [31:0] best_p_r [3];

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic [1:0]             mi, ui;
  logic signed [DOT_W:0]  dot_h;
  logic signed [P_W:0]    prod_h;
  logic signed [AX_W-1:0] axial;
  logic [64:0]            sq_sum;
  logic [63:0]            rt;
  logic signed [33:0]     dev_w;
  logic [32:0]            dev_mag, best_mag;
  logic signed [R_W-1:0]  r_abs [3];

  assign status.last = last_r;

  always_comb begin
    case (cmd.op)
      OP_D1, OP_A1, OP_S1: mi = 2'd1;
      OP_D2, OP_A2, OP_S2: mi = 2'd2;
      default:             mi = 2'd0;
    endcase
    case (cmd.op)
      OP_D2, OP_A2, OP_S2: ui = 2'd1;
      OP_D3, OP_A3, OP_S3: ui = 2'd2;
      default:             ui = 2'd0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.op)
      OP_D0, OP_D1, OP_D2: begin
        mul_a = MA_W'(v_r[mi]);
        mul_b = MB_W'(dir_r[mi]);
      end
      OP_A0, OP_A1, OP_A2: begin
        mul_a = MA_W'(proj_r);
        mul_b = MB_W'(dir_r[mi]);
      end
      OP_S0, OP_S1, OP_S2: begin
        mul_a = signed'(MA_W'({1'b0, mag_r[mi]}));
        mul_b = signed'({1'b0, mag_r[mi]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dot_h  = (DOT_W+1)'(dot_r) + DOT_HALF;
  assign prod_h = (P_W+1)'(prod_r) + P_HALF;
  assign axial  = signed'(AX_W'(prod_h >>> FRAC_BITS));
  assign sq_sum = {1'b0, sq_r} + {1'b0, prod_r[63:0]};
  assign rt     = root_r + bit_r;
  assign dev_w  = signed'({2'b00, root_r[31:0]}) - signed'({3'b000, radius_r});
  assign dev_mag  = dev_r[31] ? 33'(-34'(dev_r)) : 33'(dev_r);
  assign best_mag = best_dev_r[31] ? 33'(-34'(best_dev_r)) : 33'(best_dev_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_abs[i] = r_r[i][R_W-1] ? -r_r[i] : r_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
      dir_r[0]    <= '0;
      dir_r[1]    <= '0;
      dir_r[2]    <= DIR_Z_RESET;
      radius_r    <= RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_r[0] <= signed'(cfg_data);
        CFG_ORIGIN_Y: origin_r[1] <= signed'(cfg_data);
        CFG_ORIGIN_Z: origin_r[2] <= signed'(cfg_data);
        CFG_DIR_X:    dir_r[0]    <= signed'(cfg_data[17:0]);
        CFG_DIR_Y:    dir_r[1]    <= signed'(cfg_data[17:0]);
        CFG_DIR_Z:    dir_r[2]    <= signed'(cfg_data[17:0]);
        CFG_RADIUS:   radius_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dev_r  <= '0;
      best_p_r[0] <= '0;
      best_p_r[1] <= '0;
      best_p_r[2] <= '0;
    end else if (cmd.op == OP_UPD) begin
      if (dev_mag > best_mag) begin
        best_dev_r <= dev_r;
        best_p_r   <= p_r;
      end
    end else if (cmd.op == OP_EMIT) begin
      best_dev_r  <= '0;
      best_p_r[0] <= '0;
      best_p_r[1] <= '0;
      best_p_r[2] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        p_r[0] <= in_point_x;
        p_r[1] <= in_point_y;
        p_r[2] <= in_point_z;
        v_r[0] <= 33'(in_point_x) - 33'(origin_r[0]);
        v_r[1] <= 33'(in_point_y) - 33'(origin_r[1]);
        v_r[2] <= 33'(in_point_z) - 33'(origin_r[2]);
        last_r <= in_last_point;
      end
      OP_D1: dot_r <= signed'(prod_r[DOT_W-1:0]);
      OP_D2, OP_D3: dot_r <= dot_r + signed'(prod_r[DOT_W-1:0]);
      OP_PROJ: proj_r <= signed'(PROJ_W'(dot_h >>> FRAC_BITS));
      OP_A1, OP_A2, OP_A3: r_r[ui] <= R_W'(v_r[ui]) - R_W'(axial);
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= r_abs[i][31:0];
          ovf_r[i] <= |r_abs[i][R_W-1:32];
        end
      end
      OP_S1: sq_r <= ovf_r[0] ? SQ_MAX : prod_r[63:0];
      OP_S2, OP_S3: sq_r <= (sq_sum[64] || ovf_r[ui]) ? SQ_MAX : sq_sum[63:0];
      OP_RINIT: begin
        rn_r   <= sq_r;
        root_r <= '0;
        bit_r  <= 64'd1 << 62;
      end
      OP_RSTEP: begin
        if (rn_r >= rt) begin
          rn_r   <= rn_r - rt;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DEV: dev_r <= (dev_w > DEV_MAX) ? DEV_MAX[31:0] : dev_w[31:0];
      OP_EMIT: begin
        out_peak_deviation <= best_dev_r;
        out_peak_x         <= best_p_r[0];
        out_peak_y         <= best_p_r[1];
        out_peak_z         <= best_p_r[2];
      end
      default: ;
    endcase
  end

endmodule

/* hdl/cylinder_surface_deviation_max_core.sv */
// Peak deviation of a point cluster from a cylinder surface. One point per
// transfer (Q16.16); each point is projected onto the configured axis, its
// radial distance is taken as a floor square root of the saturated 64-bit
// squared norm, and the configured radius is subtracted. The deviation of
// largest magnitude and its point are kept, and are given out as one
// transfer on the point marked last, after which the peak clears. A point
// occupies the block from its transfer: first a sequence through one
// shared multiplier (three dot-product terms, three axial products, three
// squares), then the bit-pair square root, then the deviation and
// the peak update. A last point then loads the result register, and
// waits to do so while the previous result is still held.
// Configuration writes belong in idle periods only.
module cylinder_surface_deviation_max_core
  import csdm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // points in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  input  logic                 in_last_point,
  // peak out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_peak_deviation,
  output logic signed [31:0]   out_peak_x,
  output logic signed [31:0]   out_peak_y,
  output logic signed [31:0]   out_peak_z
);

`include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;

  // sequencer: one op per cycle, owns the handshakes
  csdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic, configuration, running peak and result register
  csdm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_point_z         (in_point_z),
    .in_last_point      (in_last_point),
    .out_peak_deviation (out_peak_deviation),
    .out_peak_x         (out_peak_x),
    .out_peak_y         (out_peak_y),
    .out_peak_z         (out_peak_z)
  );

  // point load only on a transfer
  `CHK_IMPLY(a_load_on_xfer, cmd.op == OP_LOAD, in_valid && in_ready, "load without transfer")
  // a point keeps the block busy
  `CHK_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready, "ready right after transfer")
  // result register never overwritten while held
  `CHK_IMPLY(a_emit_free, cmd.op == OP_EMIT, !out_valid || out_ready, "result overwritten")
  // emit always presents a result
  `CHK_NEXT(a_emit_valid, cmd.op == OP_EMIT, out_valid, "emit without valid")

endmodule

/* dv/tb.sv */
module tb;
  import csdm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  // watchdog: covers a point's time in the block, plus sender gaps and receiver stalls
  localparam int STALL_LIMIT = 5000;
  localparam logic [63:0] SQ_SAT = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] dev;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } peak_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ORIGIN_X;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_peak_deviation, out_peak_x, out_peak_y, out_peak_z;

  cylinder_surface_deviation_max_core #(.FRAC_BITS(FRAC)) i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the configuration and running peak
  logic signed [31:0] org_x, org_y, org_z;
  logic signed [17:0] dir_x, dir_y, dir_z;
  logic [30:0] radius;
  peak_t running_peak;
  peak_t peak_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_stall_on = 1'b1;

  function automatic longint round_frac(longint v);
    return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;   // arithmetic shift = floor
  endfunction

  function automatic logic [63:0] sq_sat(longint r);
    logic [63:0] a;
    a = (r < 0) ? 64'(-r) : 64'(r);
    if (a >= 64'h1_0000_0000) return SQ_SAT;
    return a * a;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SQ_SAT : s[63:0];
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'h1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[31:0];
  endfunction

  // deviation of one point from the cylinder surface
  function automatic logic signed [31:0] surface_dev(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz);
    longint vx, vy, vz, proj, rx, ry, rz, dv;
    vx = longint'(px) - longint'(org_x);
    vy = longint'(py) - longint'(org_y);
    vz = longint'(pz) - longint'(org_z);
    proj = round_frac(vx * dir_x + vy * dir_y + vz * dir_z);
    rx = vx - round_frac(proj * dir_x);
    ry = vy - round_frac(proj * dir_y);
    rz = vz - round_frac(proj * dir_z);
    dv = longint'({32'd0, floor_root(add_sat(add_sat(sq_sat(rx), sq_sat(ry)), sq_sat(rz)))})
         - longint'({33'd0, radius});
    if (dv > 64'sd2147483647) dv = 64'sd2147483647;
    return dv[31:0];
  endfunction

  function automatic longint mag32(logic signed [31:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic void track_point(logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] pz, logic last);
    logic signed [31:0] d;
    d = surface_dev(px, py, pz);
    if (mag32(d) > mag32(running_peak.dev)) running_peak = '{d, px, py, pz};
    if (last) begin
      peak_queue.insert(peak_queue.size(), running_peak);
      running_peak = '0;
    end
  endfunction

  // register write, mirrored into the predictor; only called while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ORIGIN_X: org_x = val;
      CFG_ORIGIN_Y: org_y = val;
      CFG_ORIGIN_Z: org_z = val;
      CFG_DIR_X:    dir_x = val[17:0];
      CFG_DIR_Y:    dir_y = val[17:0];
      CFG_DIR_Z:    dir_z = val[17:0];
      CFG_RADIUS:   radius = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_axis(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
      logic [17:0] dx, logic [17:0] dy, logic [17:0] dz, logic [30:0] r);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, 32'(signed'(dx)));
    write_reg(CFG_DIR_Y, 32'(signed'(dy)));
    write_reg(CFG_DIR_Z, 32'(signed'(dz)));
    write_reg(CFG_RADIUS, {1'b0, r});
  endtask

  // one point transfer; valid is held through ready-low cycles, payload fixed
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] pz, logic last);
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    track_point(px, py, pz, last);
    @(negedge clk);
  endtask

  // sender gap: usually none, sometimes a burst break
  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(negedge clk);
    end
  endtask

  task automatic finish_sending();
    in_valid <= 1'b0;
  endtask

  // wait for all peaks, then let a stray emit surface before touching config
  task automatic drain();
    finish_sending();
    while (peak_queue.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(bit wide);
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      default: return wide ? $urandom : $signed($urandom_range(0, 32'h00A0_0000))
                                        - 32'sh0050_0000;
    endcase
  endfunction

  task automatic test_reset_axis();
    // reset axis is the z axis through the origin, radius 1.0
    send_point(32'sh0001_0000, 0, 32'sh0012_3456, 1'b0);   // on the surface
    send_point(32'sh0003_0000, 32'sh0000_8000, -5, 1'b0);
    send_point(0, 0, 0, 1'b1);                              // on the axis
    send_point(32'sh0001_0000, 0, 0, 1'b1);                 // zero deviation only
    drain();
  endtask

  task automatic test_extremes();
    set_axis(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 18'sd0, 18'sd0, 18'sd0, 31'd0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0); // saturating norm
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b1);
    drain();
    set_axis(0, 0, 0, -18'sd65536, 18'sd0, 18'sd0, 31'h7FFF_FFFF);
    send_point(32'sh7FFF_FFFF, 0, 0, 1'b0);
    send_point(0, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    drain();
    // non-unit and extreme directions
    set_axis(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_FFFF,
             18'sh1FFFF, -18'sh20000, 18'sd46341, 31'd12345);
    send_point(32'sh0ABC_DEF0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_point(-1, 1, -1, 1'b1);
    drain();
  endtask

  task automatic test_ties();
    set_axis(0, 0, 0, 18'sd0, 18'sd0, 18'sd65536, 31'h0002_0000);
    send_point(32'sh0003_0000, 0, 0, 1'b0);   // +1.0
    send_point(32'sh0001_0000, 0, 0, 1'b0);   // -1.0, equal magnitude, kept point stays
    send_point(0, 32'sh0003_0000, 0, 1'b1);   // +1.0 again
    send_point(32'sh0002_0000, 0, 7, 1'b1);   // all zero: point (0,0,0)
    drain();
  endtask

  task automatic test_random_clusters(int n_items);
    int sent;
    int len;
    bit wide;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        set_axis($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000F_FFFF),
                 $urandom_range(0, 1) ? $urandom : 32'd0,
                 $urandom,
                 18'($urandom), 18'($signed($urandom_range(0, 131072)) - 65536),
                 18'($signed($urandom_range(0, 131072)) - 65536),
                 $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000)));
      end
      len = $urandom_range(1, 12);
      wide = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        send_point(rand_coord(wide), rand_coord(wide), rand_coord(wide), k == len - 1);
        sender_gap();
        sent++;
      end
    end
    drain();
  endtask

  // receiver: alternates between a stalling pattern and always-ready stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_stall_on <= ~rx_stall_on;
    out_ready <= rx_stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (peak_queue.size() == 0) begin
        $display("%0t: unexpected peak transfer dev=%h", $realtime, out_peak_deviation);
        errors++;
      end else begin
        peak_t exp_peak;
        exp_peak = peak_queue.pop_front();
        if (exp_peak.dev !== out_peak_deviation)
          $display("%0t: deviation exp %h got %h", $realtime, exp_peak.dev,
                   out_peak_deviation);
        if (exp_peak.x !== out_peak_x)
          $display("%0t: peak x exp %h got %h", $realtime, exp_peak.x, out_peak_x);
        if (exp_peak.y !== out_peak_y)
          $display("%0t: peak y exp %h got %h", $realtime, exp_peak.y, out_peak_y);
        if (exp_peak.z !== out_peak_z)
          $display("%0t: peak z exp %h got %h", $realtime, exp_peak.z, out_peak_z);
        if (exp_peak !== {out_peak_deviation, out_peak_x, out_peak_y, out_peak_z})
          errors++;
      end
    end
  end

  // watchdog on cycles with no transfer on either channel while points or peaks are pending
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid && peak_queue.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    org_x = 0; org_y = 0; org_z = 0;
    dir_x = 0; dir_y = 0; dir_z = DIR_Z_RESET;
    radius = RADIUS_RESET;
    running_peak = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_axis();
    test_extremes();
    test_ties();
    test_random_clusters(1400);
    if (errors == 0 && peak_queue.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
